FILE: hdl/fdalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdalu_pkg: shared types and constants of the floor-division integer ALU
// Opcodes, word types of both directions and the divider step record.
// ----------------------------------------------------------------------------
package fdalu_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int HALF_WIDTH = DATA_WIDTH / 2;
    localparam int SHAMT_BITS = $clog2(DATA_WIDTH);
    localparam int DIV_STEPS  = DATA_WIDTH;
    // Input register, decode stage, divider entry, one stage per quotient
    // bit, two fix-up stages.
    localparam int LATENCY    = DIV_STEPS + 5;

    localparam logic [3:0] FUNC_ADD  = 4'd0;
    localparam logic [3:0] FUNC_SUB  = 4'd1;
    localparam logic [3:0] FUNC_MUL  = 4'd2;
    localparam logic [3:0] FUNC_MOD  = 4'd3;
    localparam logic [3:0] FUNC_DIV  = 4'd4;
    localparam logic [3:0] FUNC_AND  = 4'd5;
    localparam logic [3:0] FUNC_OR   = 4'd6;
    localparam logic [3:0] FUNC_XOR  = 4'd7;
    localparam logic [3:0] FUNC_SHL  = 4'd8;
    localparam logic [3:0] FUNC_SHR  = 4'd9;
    localparam logic [3:0] FUNC_NEG  = 4'd10;
    localparam logic [3:0] FUNC_NOT  = 4'd11;

    typedef struct packed {
        logic [3:0]                   func;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result;
        logic                         div_by_zero;
    } t_out_word;

    // One stage of the restoring divider; the quotient bits shift into dvd.
    typedef struct packed {
        logic                  vld;
        logic [3:0]            func;
        logic [DATA_WIDTH-1:0] early;
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] dvd;
        logic [DATA_WIDTH-1:0] dvs;
        logic                  sa;
        logic                  sb;
        logic                  special;
        logic                  bz;
    } t_div_st;

    function automatic t_div_st div_step(input t_div_st s);
        t_div_st       o;
        logic [DATA_WIDTH:0] sh;
        logic [DATA_WIDTH:0] diff;
        o    = s;
        sh   = {s.rem, s.dvd[DATA_WIDTH-1]};
        diff = sh - {1'b0, s.dvs};
        o.dvd = {s.dvd[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
        o.rem = diff[DATA_WIDTH] ? sh[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
        return o;
    endfunction

endpackage

FILE: hdl/floor_div_integer_alu_64_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floor_div_integer_alu_64_core: pipelined 64-bit signed integer ALU
// Add, subtract, multiply, floor division, floor modulo, logic and shifts.
// ----------------------------------------------------------------------------
// Usage: a word is taken at every rising edge where start is high and busy
// is low; busy is low at all times outside reset, so one word may enter in
// every cycle. Every word gives exactly one result word, shown on o_result
// for one cycle with o_strobe high, in the order the words came in. The
// receiver cannot stall the block. Every operation takes the same latency
// from acceptance to the strobed result: the division path sets it, a
// restoring divider that resolves one quotient bit in each of its 64
// pipeline stages. The multiplier is split into three 32 by 32 partial
// products that are summed one stage later. Division and
// modulo by zero return 0 with div_by_zero set; a divisor of minus one gives
// the wrapped negation for division and 0 for modulo. Shifts take a signed
// amount, a negative amount reverses the direction, and a magnitude of 64 or
// more gives 0. Right shifts are logical.
// ----------------------------------------------------------------------------
module floor_div_integer_alu_64_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  fdalu_pkg::t_in_word  i_word,
    output logic                 o_strobe,
    output fdalu_pkg::t_out_word o_result
);
    import fdalu_pkg::*;

    // Stage A: input register.
    logic     r_a_vld;
    t_in_word r_a_word;

    // Stage B: decode, simple operations, partial products, magnitudes.
    logic                  r_b_vld;
    logic [3:0]            r_b_func;
    logic [DATA_WIDTH-1:0] r_b_simple;
    logic [DATA_WIDTH-1:0] r_b_pp0;
    logic [HALF_WIDTH-1:0] r_b_pp1;
    logic [HALF_WIDTH-1:0] r_b_pp2;
    logic [DATA_WIDTH-1:0] r_b_mag_a;
    logic [DATA_WIDTH-1:0] r_b_mag_b;
    logic                  r_b_sa;
    logic                  r_b_sb;
    logic                  r_b_special;
    logic                  r_b_bz;

    // Divider pipeline: entry stage plus one stage per quotient bit.
    t_div_st r_d [0:DIV_STEPS];

    // Fix-up stage one.
    logic                  r_f_vld;
    logic [3:0]            r_f_func;
    logic [DATA_WIDTH-1:0] r_f_early;
    logic [DATA_WIDTH-1:0] r_f_quo;
    logic [DATA_WIDTH-1:0] r_f_mod_mag;
    logic                  r_f_mod_neg;
    logic                  r_f_special;
    logic                  r_f_bz;

    // Output register.
    logic      r_o_vld;
    t_out_word r_o_word;

    logic                  accept;
    logic [DATA_WIDTH-1:0] a_u;
    logic [DATA_WIDTH-1:0] b_u;
    logic                  is_divop;
    logic                  b_zero;
    logic                  b_mone;
    logic                  sh_rev;
    logic [DATA_WIDTH-1:0] sh_mag;
    logic                  sh_left;
    logic [DATA_WIDTH-1:0] sh_res;
    logic [DATA_WIDTH-1:0] n_simple;
    logic [DATA_WIDTH-1:0] mul_sum;
    t_div_st               n_d0;
    t_div_st               d_last;
    logic                  corr;
    logic                  q_neg;
    logic [DATA_WIDTH-1:0] n_quo;
    logic [DATA_WIDTH-1:0] n_mod_mag;
    logic                  n_mod_neg;
    t_out_word             n_o_word;

    // The block never holds the sender off except in reset.
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // ---------------- Stage B logic ----------------
    always_comb begin
        a_u      = $unsigned(r_a_word.operand_a);
        b_u      = $unsigned(r_a_word.operand_b);
        is_divop = (r_a_word.func == FUNC_MOD) || (r_a_word.func == FUNC_DIV);
        b_zero   = (b_u == '0);
        b_mone   = (b_u == '1);

        // A negative shift amount flips the direction of the shift.
        sh_rev  = b_u[DATA_WIDTH-1];
        sh_mag  = sh_rev ? (~b_u + 1'b1) : b_u;
        sh_left = (r_a_word.func == FUNC_SHL) ^ sh_rev;
        if (sh_mag[DATA_WIDTH-1:SHAMT_BITS] != '0) begin
            sh_res = '0;
        end else if (sh_left) begin
            sh_res = a_u << sh_mag[SHAMT_BITS-1:0];
        end else begin
            sh_res = a_u >> sh_mag[SHAMT_BITS-1:0];
        end

        case (r_a_word.func)
            FUNC_ADD: n_simple = a_u + b_u;
            FUNC_SUB: n_simple = a_u - b_u;
            FUNC_AND: n_simple = a_u & b_u;
            FUNC_OR:  n_simple = a_u | b_u;
            FUNC_XOR: n_simple = a_u ^ b_u;
            FUNC_SHL: n_simple = sh_res;
            FUNC_SHR: n_simple = sh_res;
            FUNC_NEG: n_simple = ~a_u + 1'b1;
            FUNC_NOT: n_simple = ~a_u;
            FUNC_DIV: n_simple = (b_mone && !b_zero) ? (~a_u + 1'b1) : '0;
            default:  n_simple = '0;
        endcase
    end

    // ---------------- Stage C logic (divider entry) ----------------
    always_comb begin
        mul_sum = r_b_pp0 + {(r_b_pp1 + r_b_pp2), {HALF_WIDTH{1'b0}}};
        n_d0.vld     = r_b_vld;
        n_d0.func    = r_b_func;
        n_d0.early   = (r_b_func == FUNC_MUL) ? mul_sum : r_b_simple;
        n_d0.rem     = '0;
        n_d0.dvd     = r_b_mag_a;
        n_d0.dvs     = r_b_mag_b;
        n_d0.sa      = r_b_sa;
        n_d0.sb      = r_b_sb;
        n_d0.special = r_b_special;
        n_d0.bz      = r_b_bz;
    end

    // ---------------- Fix-up logic ----------------
    always_comb begin
        d_last = r_d[DIV_STEPS];
        // Signs differ and a remainder is left: round the quotient down and
        // move the remainder over to the sign of the divisor.
        q_neg = d_last.sa ^ d_last.sb;
        corr  = q_neg && (d_last.rem != '0);
        if (corr) begin
            n_quo = ~d_last.dvd;
        end else if (q_neg) begin
            n_quo = ~d_last.dvd + 1'b1;
        end else begin
            n_quo = d_last.dvd;
        end
        n_mod_mag = corr ? (d_last.dvs - d_last.rem) : d_last.rem;
        n_mod_neg = corr ? d_last.sb : d_last.sa;
    end

    always_comb begin
        n_o_word.div_by_zero = r_f_bz &&
                               ((r_f_func == FUNC_MOD) || (r_f_func == FUNC_DIV));
        if (r_f_special) begin
            n_o_word.result = $signed(r_f_early);
        end else if (r_f_func == FUNC_DIV) begin
            n_o_word.result = $signed(r_f_quo);
        end else if (r_f_func == FUNC_MOD) begin
            n_o_word.result = r_f_mod_neg ? $signed(~r_f_mod_mag + 1'b1)
                                          : $signed(r_f_mod_mag);
        end else begin
            n_o_word.result = $signed(r_f_early);
        end
    end

    // ---------------- Valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_a_vld <= accept;
            r_b_vld <= r_a_vld;
            r_f_vld <= r_d[DIV_STEPS].vld;
            r_o_vld <= r_f_vld;
        end
    end

    // ---------------- Payload registers ----------------
    always_ff @(posedge i_clk) begin
        r_a_word <= i_word;

        r_b_func    <= r_a_word.func;
        r_b_simple  <= n_simple;
        r_b_pp0     <= a_u[HALF_WIDTH-1:0] * b_u[HALF_WIDTH-1:0];
        r_b_pp1     <= HALF_WIDTH'(a_u[HALF_WIDTH-1:0] * b_u[DATA_WIDTH-1:HALF_WIDTH]);
        r_b_pp2     <= HALF_WIDTH'(a_u[DATA_WIDTH-1:HALF_WIDTH] * b_u[HALF_WIDTH-1:0]);
        r_b_mag_a   <= a_u[DATA_WIDTH-1] ? (~a_u + 1'b1) : a_u;
        r_b_mag_b   <= b_u[DATA_WIDTH-1] ? (~b_u + 1'b1) : b_u;
        r_b_sa      <= a_u[DATA_WIDTH-1];
        r_b_sb      <= b_u[DATA_WIDTH-1];
        r_b_special <= is_divop && (b_zero || b_mone);
        r_b_bz      <= b_zero;

        r_f_func    <= d_last.func;
        r_f_early   <= d_last.early;
        r_f_quo     <= n_quo;
        r_f_mod_mag <= n_mod_mag;
        r_f_mod_neg <= n_mod_neg;
        r_f_special <= d_last.special;
        r_f_bz      <= d_last.bz;

        r_o_word <= n_o_word;
    end

    // Divider stages; the valid bit of each stage is cleared in reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DIV_STEPS; i++) begin
                r_d[i].vld <= 1'b0;
            end
        end else begin
            r_d[0] <= n_d0;
            for (int i = 0; i < DIV_STEPS; i++) begin
                r_d[i+1] <= div_step(r_d[i]);
            end
        end
    end

    assign o_strobe = r_o_vld;
    assign o_result = r_o_word;

endmodule

FILE: hdl/fdalu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdalu_checker: port-level checks of the floor-division integer ALU
// Watches the top level's ports and reports violations by $error.
// ----------------------------------------------------------------------------
module fdalu_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input fdalu_pkg::t_in_word  i_word,
    input logic                 o_strobe,
    input fdalu_pkg::t_out_word o_result
);
    import fdalu_pkg::*;

    logic [$clog2(LATENCY+1)-1:0] r_age;
    logic                         warm;

    // Cycles since reset, saturating once a full pipeline has drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age <= '0;
        end else if (!warm) begin
            r_age <= r_age + 1'b1;
        end
    end
    assign warm = (r_age == ($clog2(LATENCY+1))'(LATENCY));

    a_strobe_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        warm |-> (o_strobe == $past(start && !busy, LATENCY)))
        else $error("result strobe does not match an accepted word");

    a_dz_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.div_by_zero) |-> (o_result.result == '0))
        else $error("divide by zero with nonzero result");

    a_dz_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (warm && o_strobe && $past(i_word.func != FUNC_MOD && i_word.func != FUNC_DIV,
                                   LATENCY))
        |-> !o_result.div_by_zero)
        else $error("divide by zero flagged for a non-division operation");

    a_dz_on_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (warm && o_strobe && $past(i_word.func == FUNC_DIV && i_word.operand_b == '0,
                                   LATENCY))
        |-> o_result.div_by_zero)
        else $error("zero divisor not flagged");

endmodule

bind floor_div_integer_alu_64_core fdalu_checker u_fdalu_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_word   (i_word),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
